>>> design/kcl_pkg.sv
package kcl_pkg;

  // Default geometry of the lock.
  localparam int CODE_DIGITS_DEF = 4;
  localparam int RESET_KEYS_DEF  = 9;

  // Keys with a meaning of their own.
  localparam logic [7:0] KEY_ZERO = 8'h30;
  localparam logic [7:0] KEY_HASH = 8'h23;
  localparam logic [7:0] KEY_STAR = 8'h2A;

  // Operating modes, one-hot.
  typedef enum logic [3:0] {
    MODE_ENTRY = 4'b0001,
    MODE_MENU  = 4'b0010,
    MODE_NEW   = 4'b0100,
    MODE_RESET = 4'b1000
  } mode_t;

  // Status reported with every result beat.
  typedef enum logic [2:0] {
    STATUS_BUSY     = 3'd0,
    STATUS_WRONG    = 3'd1,
    STATUS_UNLOCKED = 3'd2,
    STATUS_EXIT     = 3'd3,
    STATUS_CHANGED  = 3'd4,
    STATUS_RESET    = 3'd5,
    STATUS_REFUSED  = 3'd6,
    STATUS_UNKNOWN  = 3'd7
  } status_t;

endpackage

>>> design/keypad_code_lock.sv
// Path: an accepted key beat waits in the input register until it is processed; its result
// beat is then presented from the result register (input register, result register).
// Throughput: one key beat per cycle while the result side does not stall; the single-pass
// update of the lock state and the parallel code compare sit between those two registers.
// Reset (rst, synchronous, active high) empties both registers, returns to code entry
// with the key count at zero and clears the stored code to all zeros.
module keypad_code_lock
  import kcl_pkg::*;
#(
  parameter int CODE_DIGITS = CODE_DIGITS_DEF,
  parameter int RESET_KEYS  = RESET_KEYS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] key_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       echo_valid,
  output logic [7:0] echo_char,
  output logic [2:0] status
);

  // The key counter must reach the last position of the longest phase.
  localparam int MAX_KEYS = (CODE_DIGITS > RESET_KEYS) ? CODE_DIGITS : RESET_KEYS;
  localparam int CNT_W    = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(CODE_DIGITS - 1);
  localparam logic [CNT_W-1:0] LAST_RESET = CNT_W'(RESET_KEYS - 1);

  // Input register: one key beat waiting to be processed.
  logic       item_valid;
  logic [7:0] item_key;

  // Lock state.
  mode_t            mode;
  logic [CNT_W-1:0] key_count;
  logic [7:0]       entered_digits [CODE_DIGITS];
  logic [7:0]       stored_code    [CODE_DIGITS];
  logic             reset_keys_ok;

  // Next values produced by the single-pass step.
  mode_t            mode_next;
  logic [CNT_W-1:0] key_count_next;
  logic [7:0]       entered_digits_next [CODE_DIGITS];
  logic [7:0]       stored_code_next    [CODE_DIGITS];
  logic             reset_keys_ok_next;
  logic             echo_valid_next;
  logic [7:0]       echo_char_next;
  status_t          status_next;

  logic       fire;
  logic [7:0] digit;

  // The held key is processed whenever the result register is free or is being
  // emptied in this same cycle. The input stalls only while a result waits and
  // a key is already held.
  assign fire     = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !fire;

  // Digits are kept as the key minus '0', wrapping modulo 256.
  assign digit = item_key - KEY_ZERO;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      item_key <= key_code;
    end
  end

  // Single-pass step of the lock. During code entry the candidate code is the
  // digits already held with the current key slotted in at its position, so the
  // compare with the stored code happens on the key that completes the entry.
  always_comb begin
    logic [7:0] candidate [CODE_DIGITS];
    logic       same;
    logic       ok_now;

    mode_next           = mode;
    key_count_next      = key_count;
    entered_digits_next = entered_digits;
    stored_code_next    = stored_code;
    reset_keys_ok_next  = reset_keys_ok;
    echo_valid_next     = 1'b0;
    echo_char_next      = 8'h00;
    status_next         = STATUS_BUSY;
    same                = 1'b1;
    ok_now              = reset_keys_ok;

    for (int i = 0; i < CODE_DIGITS; i++) begin
      candidate[i] = (CNT_W'(i) == key_count) ? digit : entered_digits[i];
      if (candidate[i] != stored_code[i]) begin
        same = 1'b0;
      end
    end

    unique case (mode)
      MODE_ENTRY: begin
        echo_valid_next     = 1'b1;
        echo_char_next      = KEY_STAR;
        entered_digits_next = candidate;
        if (key_count == LAST_DIGIT) begin
          key_count_next = '0;
          if (same) begin
            status_next = STATUS_UNLOCKED;
            mode_next   = MODE_MENU;
          end else begin
            status_next = STATUS_WRONG;
            mode_next   = MODE_ENTRY;
          end
        end else begin
          key_count_next = key_count + 1'b1;
        end
      end
      MODE_MENU: begin
        key_count_next = '0;
        if (item_key == KEY_HASH) begin
          mode_next = MODE_NEW;
        end else if (item_key == KEY_STAR) begin
          status_next = STATUS_EXIT;
          mode_next   = MODE_ENTRY;
        end else if (item_key == KEY_ZERO) begin
          echo_valid_next    = 1'b1;
          echo_char_next     = item_key;
          mode_next          = MODE_RESET;
          reset_keys_ok_next = 1'b1;
        end else begin
          status_next = STATUS_UNKNOWN;
          mode_next   = MODE_ENTRY;
        end
      end
      MODE_NEW: begin
        echo_valid_next = 1'b1;
        echo_char_next  = KEY_STAR;
        // Each new digit goes straight into the stored code.
        for (int i = 0; i < CODE_DIGITS; i++) begin
          if (CNT_W'(i) == key_count) begin
            stored_code_next[i] = digit;
          end
        end
        if (key_count == LAST_DIGIT) begin
          status_next    = STATUS_CHANGED;
          mode_next      = MODE_ENTRY;
          key_count_next = '0;
        end else begin
          key_count_next = key_count + 1'b1;
        end
      end
      MODE_RESET: begin
        echo_valid_next = 1'b1;
        echo_char_next  = item_key;
        // The first gathered key is free; every later one must be '0'.
        if (key_count != '0 && item_key != KEY_ZERO) begin
          ok_now = 1'b0;
        end
        reset_keys_ok_next = ok_now;
        if (key_count == LAST_RESET) begin
          if (ok_now) begin
            status_next = STATUS_RESET;
            for (int i = 0; i < CODE_DIGITS; i++) begin
              stored_code_next[i] = 8'h00;
            end
          end else begin
            status_next = STATUS_REFUSED;
          end
          reset_keys_ok_next = 1'b1;
          mode_next          = MODE_ENTRY;
          key_count_next     = '0;
        end else begin
          key_count_next = key_count + 1'b1;
        end
      end
      default: begin
        mode_next      = MODE_ENTRY;
        key_count_next = '0;
      end
    endcase
  end

  // Lock state. The entered digits need no reset: each is written before the
  // compare that reads it.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_ENTRY;
      key_count     <= '0;
      reset_keys_ok <= 1'b1;
      for (int i = 0; i < CODE_DIGITS; i++) begin
        stored_code[i] <= 8'h00;
      end
    end else if (fire) begin
      mode          <= mode_next;
      key_count     <= key_count_next;
      reset_keys_ok <= reset_keys_ok_next;
      stored_code   <= stored_code_next;
    end
    if (fire) begin
      entered_digits <= entered_digits_next;
    end
  end

  // Result register. It holds its beat while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (fire) begin
      echo_valid <= echo_valid_next;
      echo_char  <= echo_char_next;
      status     <= 3'(status_next);
    end
  end

  // A result without an echo carries no character.
  a_echo_blank: assert property (@(posedge clk) disable iff (rst)
    out_valid && !echo_valid |-> echo_char == 8'h00)
    else $error("result without echo carries a character");

  // The menu is always entered with a fresh key count.
  a_menu_count: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_MENU |-> key_count == '0)
    else $error("key count not zero in menu mode");

  // The key count never passes the last code position during code entry or a new code.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_ENTRY || mode == MODE_NEW) |-> key_count <= LAST_DIGIT)
    else $error("key count beyond code length");

  // The first new-code key lands in the stored code at position 0.
  a_new_digit: assert property (@(posedge clk) disable iff (rst)
    fire && mode == MODE_NEW && key_count == '0 |=> stored_code[0] == $past(digit))
    else $error("new code digit not stored");

  // A completed phase always hands back to code entry.
  a_back_to_entry: assert property (@(posedge clk) disable iff (rst)
    fire && status_next != STATUS_BUSY && status_next != STATUS_UNLOCKED
    |=> mode == MODE_ENTRY && key_count == '0)
    else $error("completed phase did not return to code entry");

endmodule

>>> test/keypad_code_lock_tb.sv
module keypad_code_lock_tb
  import kcl_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // The lock is built with its default geometry, and the predictor below uses
  // the same numbers.
  localparam int CODE_DIGITS = CODE_DIGITS_DEF;
  localparam int RESET_KEYS  = RESET_KEYS_DEF;

  // Number of random key beats that follow the directed tests.
  localparam int RANDOM_KEYS = 1400;

  // One result beat as the lock presents it.
  typedef struct {
    logic       echo_valid;
    logic [7:0] echo_char;
    status_t    status;
  } lock_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] key_code = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       echo_valid;
  logic [7:0] echo_char;
  logic [2:0] status;

  // Predicted copy of the lock state. It is advanced once for every key beat
  // that the lock accepts, so it always mirrors what the lock should hold.
  mode_t      lock_mode = MODE_ENTRY;
  int         key_count = 0;
  logic [7:0] typed_digits [CODE_DIGITS];
  logic [7:0] lock_code [CODE_DIGITS];
  logic       reset_keys_ok = 1'b1;

  // Results still owed by the lock, oldest first.
  lock_result_t pending_results [$];

  int  keys_sent = 0;
  int  error_count = 0;
  bit  no_idle = 1'b0;
  int  stall_left = 0;

  keypad_code_lock #(
    .CODE_DIGITS(CODE_DIGITS),
    .RESET_KEYS (RESET_KEYS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .key_code  (key_code),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .echo_valid(echo_valid),
    .echo_char (echo_char),
    .status    (status)
  );

  // A 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The stored code starts out as all zeros, just as the lock's reset leaves it.
  initial begin
    for (int i = 0; i < CODE_DIGITS; i++) begin
      lock_code[i] = 8'h00;
      typed_digits[i] = 8'h00;
    end
  end

  // Length of one idle stretch: mostly a short one, now and then a long one.
  function automatic int idle_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Gap in front of a key beat. Most beats go back to back; while no_idle is set,
  // all of them do.
  function automatic int input_gap();
    if (no_idle || $urandom_range(0, 2) != 0) return 0;
    return idle_length();
  endfunction

  // The result side stalls at random, in bursts of the same shape as the input gaps.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!no_idle && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left <= idle_length() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Prints a mismatch and counts it.
  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Advances the predicted lock state by one key and returns the result that the
  // lock owes for it. Keys are held as (key - '0') modulo 256, so any key can
  // take part in a code, not only the digits.
  task automatic predict_lock(input logic [7:0] k, output lock_result_t r);
    logic [7:0] digit;
    logic       same;
    digit = k - KEY_ZERO;
    r.echo_valid = 1'b0;
    r.echo_char  = 8'h00;
    r.status     = STATUS_BUSY;
    case (lock_mode)
      MODE_ENTRY: begin
        // During code entry every key is shown as a star.
        r.echo_valid = 1'b1;
        r.echo_char  = KEY_STAR;
        typed_digits[key_count] = digit;
        if (key_count == CODE_DIGITS - 1) begin
          same = 1'b1;
          for (int i = 0; i < CODE_DIGITS; i++) begin
            if (typed_digits[i] != lock_code[i]) same = 1'b0;
          end
          r.status  = same ? STATUS_UNLOCKED : STATUS_WRONG;
          lock_mode = same ? MODE_MENU : MODE_ENTRY;
          key_count = 0;
        end else begin
          key_count++;
        end
      end
      MODE_MENU: begin
        // The menu choice itself is only shown for the reset choice.
        key_count = 0;
        if (k == KEY_HASH) begin
          lock_mode = MODE_NEW;
        end else if (k == KEY_STAR) begin
          r.status  = STATUS_EXIT;
          lock_mode = MODE_ENTRY;
        end else if (k == KEY_ZERO) begin
          r.echo_valid  = 1'b1;
          r.echo_char   = k;
          lock_mode     = MODE_RESET;
          reset_keys_ok = 1'b1;
        end else begin
          r.status  = STATUS_UNKNOWN;
          lock_mode = MODE_ENTRY;
        end
      end
      MODE_NEW: begin
        // Each new digit goes straight into the stored code.
        r.echo_valid = 1'b1;
        r.echo_char  = KEY_STAR;
        lock_code[key_count] = digit;
        if (key_count == CODE_DIGITS - 1) begin
          r.status  = STATUS_CHANGED;
          lock_mode = MODE_ENTRY;
          key_count = 0;
        end else begin
          key_count++;
        end
      end
      default: begin
        // Gathering reset keys: the first one may be anything, all later ones
        // must be '0' for the stored code to be cleared.
        r.echo_valid = 1'b1;
        r.echo_char  = k;
        if (key_count >= 1 && k != KEY_ZERO) reset_keys_ok = 1'b0;
        if (key_count == RESET_KEYS - 1) begin
          if (reset_keys_ok) begin
            for (int i = 0; i < CODE_DIGITS; i++) lock_code[i] = 8'h00;
            r.status = STATUS_RESET;
          end else begin
            r.status = STATUS_REFUSED;
          end
          reset_keys_ok = 1'b1;
          lock_mode     = MODE_ENTRY;
          key_count     = 0;
        end else begin
          key_count++;
        end
      end
    endcase
  endtask

  // Sends one key beat after a random gap and waits until the lock takes it. The
  // expected result is worked out at the edge that accepts the beat; the result
  // cannot come out before the next edge, so the checker always finds it queued.
  task automatic send_key(input logic [7:0] k);
    lock_result_t want;
    int gap;
    gap = input_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    key_code <= k;
    do @(posedge clk); while (in_stall);
    predict_lock(k, want);
    pending_results.push_back(want);
    keys_sent++;
  endtask

  // Every result beat is checked against the oldest expected result.
  always @(posedge clk) begin
    lock_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected (status %0d)", status));
      end else begin
        want = pending_results.pop_front();
        if (echo_valid !== want.echo_valid)
          report_mismatch($sformatf("echo_valid %b, expected %b", echo_valid, want.echo_valid));
        if (echo_char !== want.echo_char)
          report_mismatch($sformatf("echo_char %h, expected %h", echo_char, want.echo_char));
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
      end
    end
  end

  // Keys a code that matches the stored one.
  task automatic unlock_lock();
    for (int i = 0; i < CODE_DIGITS; i++) send_key(lock_code[i] + KEY_ZERO);
  endtask

  // A key of any kind: digits and the two symbol keys are favored.
  function automatic logic [7:0] random_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return KEY_ZERO + 8'($urandom_range(0, 9));
    if (r == 5) return KEY_HASH;
    if (r == 6) return KEY_STAR;
    return 8'($urandom_range(1, 255));
  endfunction

  // A key that is neither '0' nor one of the menu keys.
  function automatic logic [7:0] plain_key();
    logic [7:0] k;
    do k = random_key(); while (k == KEY_ZERO || k == KEY_HASH || k == KEY_STAR);
    return k;
  endfunction

  // Feeds random keys until the lock is back at the start of code entry.
  task automatic settle_to_entry();
    while (lock_mode != MODE_ENTRY || key_count != 0) send_key(random_key());
  endtask

  // Keys that are not a code at all, including the extreme key values and the
  // menu keys, which mean nothing during entry.
  task automatic test_wrong_code();
    send_key(8'h01);
    send_key(8'hFF);
    send_key(KEY_STAR);
    send_key(KEY_HASH);
  endtask

  // Unlocks with the all-zero code of a fresh lock, then leaves the menu with
  // '*' and, the second time, with a key that is not a menu choice.
  task automatic test_menu_choices();
    unlock_lock();
    send_key(KEY_STAR);
    unlock_lock();
    send_key("A");
  endtask

  // Stores a new code that uses both extreme key values, then proves it by
  // unlocking with it.
  task automatic test_code_change();
    unlock_lock();
    send_key(KEY_HASH);
    send_key(8'hFF);
    send_key(8'h01);
    send_key("9");
    send_key(KEY_ZERO);
    unlock_lock();
    send_key(KEY_STAR);
  endtask

  // The reset menu: first a sequence that clears the code (its first key may be
  // anything), then one spoiled by a stray key, which must leave the code alone.
  task automatic test_code_reset();
    unlock_lock();
    send_key(KEY_ZERO);
    send_key("7");
    for (int i = 1; i < RESET_KEYS; i++) send_key(KEY_ZERO);
    unlock_lock();
    send_key(KEY_ZERO);
    for (int i = 0; i < RESET_KEYS; i++) send_key(i == 4 ? KEY_HASH : KEY_ZERO);
    unlock_lock();
    send_key(KEY_STAR);
  endtask

  // Mostly well-formed sessions with random content, mixed with wrong codes and
  // loose keys. Stretches without any idling on either side come and go.
  task automatic test_random_sessions();
    int first_key;
    int pick;
    int odd_spot;
    logic [7:0] attempt [CODE_DIGITS];
    first_key = keys_sent;
    while (keys_sent - first_key < RANDOM_KEYS) begin
      if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
      settle_to_entry();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        unlock_lock();
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          send_key(KEY_HASH);
          for (int i = 0; i < CODE_DIGITS; i++)
            send_key($urandom_range(0, 3) != 0 ? KEY_ZERO + 8'($urandom_range(0, 9))
                                               : 8'($urandom_range(1, 255)));
        end else if (pick < 70) begin
          // Two thirds of the reset sequences are clean, the rest have one random
          // key somewhere after the first.
          send_key(KEY_ZERO);
          odd_spot = ($urandom_range(0, 2) == 0) ? $urandom_range(1, RESET_KEYS - 1) : 0;
          send_key(random_key());
          for (int i = 1; i < RESET_KEYS; i++) begin
            if (i == odd_spot) begin
              send_key(($urandom_range(0, 1) == 0) ? plain_key() : random_key());
            end else begin
              send_key(KEY_ZERO);
            end
          end
        end else if (pick < 85) begin
          send_key(KEY_STAR);
        end else begin
          send_key(plain_key());
        end
      end else if (pick < 90) begin
        // A near miss: the right code with one key changed, or no code at all.
        for (int i = 0; i < CODE_DIGITS; i++) attempt[i] = lock_code[i] + KEY_ZERO;
        if ($urandom_range(0, 1) == 0) begin
          odd_spot = $urandom_range(0, CODE_DIGITS - 1);
          attempt[odd_spot] = random_key();
        end else begin
          for (int i = 0; i < CODE_DIGITS; i++) attempt[i] = 8'($urandom_range(1, 255));
        end
        for (int i = 0; i < CODE_DIGITS; i++) send_key(attempt[i]);
      end else begin
        pick = $urandom_range(1, 6);
        for (int i = 0; i < pick; i++) send_key(8'($urandom_range(1, 255)));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_wrong_code();
    test_menu_choices();
    test_code_change();
    test_code_reset();
    test_random_sessions();

    // Let the last beats drain until every expected result is checked, then wait out a margin.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: a correct run takes well under a tenth of this, even with every
  // key waiting out the longest gaps and stalls.
  initial begin
    #10ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
